// ----- hw/rtl/cbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_pkg: shared definitions for the cartridge bank controller
// Widths, address ranges, register indexes and the access decode record.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // Built store and ROM address space
  localparam int RAM_BYTES     = 8192;
  localparam int ROM_ADDR_BITS = 19;
  localparam int RAM_ADDR_W    = $clog2(RAM_BYTES);

  // Field widths
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int ROM_LOC_W  = 19;
  localparam int ROM_BANK_W = 9;
  localparam int RAM_BANK_W = 4;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int RAM_LOC_W  = RAM_BANK_W + 13;
  localparam int ROM_FULL_W = ROM_BANK_W + 14;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RUMBLE      = 2'd3;

  // Mapper codes; every other code behaves as bankless
  localparam logic [1:0] MAPPER_MBC1 = 2'd1;
  localparam logic [1:0] MAPPER_MBC5 = 2'd2;

  // Bus address ranges
  localparam logic [ADDR_W-1:0] RAM_EN_LAST   = 16'h1fff;
  localparam logic [ADDR_W-1:0] ROM_LO_LAST   = 16'h2fff;
  localparam logic [ADDR_W-1:0] ROM_BANK_LAST = 16'h3fff;
  localparam logic [ADDR_W-1:0] RAM_BANK_LAST = 16'h5fff;
  localparam logic [ADDR_W-1:0] ROM_WIN_END   = 16'h8000;
  localparam logic [ADDR_W-1:0] ROM_FIXED_END = 16'h4000;
  localparam logic [ADDR_W-1:0] RAM_WIN_FIRST = 16'ha000;
  localparam logic [ADDR_W-1:0] RAM_WIN_LAST  = 16'hbfff;

  localparam logic [3:0]       RAM_EN_KEY  = 4'ha;
  localparam logic [DATA_W-1:0] OPEN_BUS   = 8'hff;
  localparam logic [ROM_FULL_W-1:0] ROM_MASK =
    ROM_FULL_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);
  localparam logic [RAM_LOC_W:0] RAM_LIMIT = (RAM_LOC_W + 1)'(RAM_BYTES);

  // Decode of one bus access against the current bank state
  typedef struct packed {
    logic                  rom_fetch;
    logic [ROM_LOC_W-1:0]  rom_location;
    logic                  ram_hit;
    logic [RAM_ADDR_W-1:0] ram_index;
  } access_t;

endpackage

// ----- hw/rtl/cbc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/cbc_mapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_mapper: configuration, bank registers and access decode
// Holds the mapper setup and bank state and decodes the incoming access.
// ----------------------------------------------------------------------------
module cbc_mapper (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           wr_accept,
  input  logic [cbc_pkg::ADDR_W-1:0]     address,
  input  logic [cbc_pkg::DATA_W-1:0]     write_data,
  output cbc_pkg::access_t               access
);
  import cbc_pkg::*;

  logic [1:0]            mapper_kind;
  logic [19:0]           rom_size;
  logic [17:0]           ram_size;
  logic                  rumble_fitted;
  logic [ROM_BANK_W-1:0] rom_bank;
  logic [RAM_BANK_W-1:0] ram_bank;
  logic                  ram_enable;

  logic                  banked;
  logic                  mbc5;
  logic [RAM_LOC_W-1:0]  ram_loc;
  logic [ROM_FULL_W-1:0] rom_full;
  logic                  rom_read;

  assign mbc5   = (mapper_kind == MAPPER_MBC5);
  assign banked = (mapper_kind == MAPPER_MBC1) || mbc5;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_kind   <= '0;
      rom_size      <= 20'd32768;
      ram_size      <= '0;
      rumble_fitted <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAPPER_KIND: mapper_kind   <= cfg_data[1:0];
        CFG_ROM_SIZE:    rom_size      <= cfg_data[19:0];
        CFG_RAM_SIZE:    ram_size      <= cfg_data[17:0];
        CFG_RUMBLE:      rumble_fitted <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control writes; bankless ignores them all
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank   <= ROM_BANK_W'(1);
      ram_bank   <= '0;
      ram_enable <= 1'b0;
    end else if (wr_accept && banked) begin
      priority if (address <= RAM_EN_LAST) begin
        ram_enable <= (write_data[3:0] == RAM_EN_KEY);
      end else if (address <= ROM_BANK_LAST) begin
        if (!mbc5) begin
          rom_bank <= (write_data[4:0] == 5'd0) ? ROM_BANK_W'(1)
                                                 : {4'd0, write_data[4:0]};
        end else if (address <= ROM_LO_LAST) begin
          rom_bank <= {rom_bank[8], write_data};
        end else begin
          rom_bank <= {write_data[0], rom_bank[7:0]};
        end
      end else if (address <= RAM_BANK_LAST) begin
        if (!mbc5) begin
          ram_bank <= {2'd0, write_data[1:0]};
        end else if (rumble_fitted) begin
          ram_bank <= {1'b0, write_data[2:0]};
        end else begin
          ram_bank <= write_data[3:0];
        end
      end
    end
  end

  // Bank times 8 KiB plus the window offset
  assign ram_loc = {ram_bank, address[12:0]};

  assign access.ram_hit = banked && ram_enable &&
                          (address >= RAM_WIN_FIRST) && (address <= RAM_WIN_LAST) &&
                          ({1'b0, ram_loc} < ram_size) &&
                          ({1'b0, ram_loc} < RAM_LIMIT);
  assign access.ram_index = ram_loc[RAM_ADDR_W-1:0];

  assign rom_read = (address < ROM_WIN_END) && ({4'd0, address} < rom_size);
  assign rom_full = (!banked || address < ROM_FIXED_END)
                    ? {7'd0, address}
                    : {rom_bank, address[13:0]};

  assign access.rom_fetch    = rom_read;
  assign access.rom_location = rom_read ? ROM_LOC_W'(rom_full & ROM_MASK) : '0;

endmodule

// ----- hw/rtl/cartridge_bank_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_controller: bankless / MBC1 / MBC5 cartridge bank controller
// Decodes host bus accesses, keeps bank state and the cartridge RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one bus access per transaction (tuser = op, 1 for write).
//   Writes update the bank registers or cartridge RAM and return nothing.
//   Each read returns one transaction on m_axis: read_data, rom_location in
//   tdata and rom_fetch in tuser; with rom_fetch set the byte comes from the
//   external ROM at rom_location.
//   Throughput: one access per cycle while s_axis_tready is high. A write's
//   bank update is seen by the access accepted in the next cycle.
//   Read path: the RAM read and the read stage load when a read is accepted,
//   and the output register loads from the read stage once it is free or
//   draining; a stalled receiver holds the result back.
//   Reset: after rst the RAM is cleared one byte per cycle, all RAM_BYTES
//   (8192) bytes, with s_axis_tready low; configuration writes are taken meanwhile.
//   Stall: the output register plus the RAM read stage hold two results; a
//   stalled receiver lets one more read in (writes pass while the read stage
//   is empty), then tready drops.
//   Configure only while no transaction is in flight.
// ----------------------------------------------------------------------------
module cartridge_bank_controller (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data,
  // bus access stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // address[15:0], write_data[23:16]
  input  logic [0:0]                     s_axis_tuser,  // op[0]
  // read result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // read_data[7:0], rom_location[26:8]
  output logic [0:0]                     m_axis_tuser   // rom_fetch[0]
);
  import cbc_pkg::*;

  logic                  in_accept;
  logic                  op;
  logic [ADDR_W-1:0]     address;
  logic [DATA_W-1:0]     write_data;
  access_t               access;

  // Clear sweep
  logic                  clearing;
  logic [RAM_ADDR_W-1:0] clr_addr;

  // RAM read stage
  logic                  s1_valid;
  logic                  s1_rom_fetch;
  logic [ROM_LOC_W-1:0]  s1_rom_location;
  logic                  s1_ram_hit;
  logic                  s1_advance;

  // Output register
  logic                  out_valid;
  logic [DATA_W-1:0]     out_read_data;
  logic                  out_rom_fetch;
  logic [ROM_LOC_W-1:0]  out_rom_location;

  logic                  ram_we;
  logic [RAM_ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0]     ram_wdata;
  logic                  ram_re;
  logic [DATA_W-1:0]     ram_rdata;

  assign op         = s_axis_tuser[0];
  assign address    = s_axis_tdata[15:0];
  assign write_data = s_axis_tdata[23:16];

  // Advance the read stage when the output register is free or draining
  assign s1_advance    = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !clearing && (!s1_valid || s1_advance);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  cbc_mapper u_mapper (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .wr_accept  (in_accept && op),
    .address    (address),
    .write_data (write_data),
    .access     (access)
  );

  // Walk the whole RAM once after reset, writing zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + RAM_ADDR_W'(1);
      if (clr_addr == RAM_ADDR_W'(RAM_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Sweep owns the write port while clearing; no access is taken then
  assign ram_we    = clearing || (in_accept && op && access.ram_hit);
  assign ram_waddr = clearing ? clr_addr : access.ram_index;
  assign ram_wdata = clearing ? '0 : write_data;
  assign ram_re    = in_accept && !op && access.ram_hit;

  cbc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RAM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (access.ram_index),
    .rdata (ram_rdata)
  );

  // Read stage: only reads produce a result
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= !op;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_rom_fetch    <= access.rom_fetch;
      s1_rom_location <= access.rom_location;
      s1_ram_hit      <= access.ram_hit;
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_read_data    <= s1_ram_hit ? ram_rdata : OPEN_BUS;
      out_rom_fetch    <= s1_rom_fetch;
      out_rom_location <= s1_rom_location;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_rom_location, out_read_data};
  assign m_axis_tuser  = out_rom_fetch;

  // No access may enter while the clear sweep owns the RAM
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("access accepted during RAM clear");

  // A read always lands in the read stage; a write never does
  a_read_enters: assert property (@(posedge clk) disable iff (rst)
    in_accept && !op |=> s1_valid)
    else $error("read lost on entry");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_accept && op |=> !s1_valid)
    else $error("write produced a result");

  // ROM and RAM windows never overlap
  a_rom_ram_excl: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(s1_rom_fetch && s1_ram_hit))
    else $error("access decoded as both ROM and RAM");

  // A stalled read stage must not be overwritten
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |-> !in_accept)
    else $error("read stage overwritten");

endmodule

// ----- verif/tb_cartridge_bank_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartridge_bank_controller: self-checking bench for the bank controller
// Streams host bus accesses through the slave side under several mapper,
// ROM size, RAM size and rumble settings. A behavioral mirror of the bank
// state and cartridge RAM predicts every read, and the monitor compares each
// read result, field by field, in order.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_controller;

  // Mirror dimensions; these track the controller build.
  localparam int RAM_DEPTH   = 8192;
  localparam int CLK_HALF_NS = 2;
  localparam int RESET_CYCLES = 11;
  // A read result passes through the read stage and the output register;
  // leave margin before touching the registers.
  localparam int SETTLE_CYCLES = 6;
  // Includes the RAM clear after reset and worst-case stalls.
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 100;
  localparam int NUM_PHASES  = 10;

  // Access kinds carried in tuser
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Mapper codes not named in the package
  localparam logic [1:0] MAPPER_BANKLESS = 2'd0;
  localparam logic [1:0] MAPPER_UNUSED   = 2'd3;

  localparam logic [15:0] RAM_WIN_BASE = 16'ha000;
  localparam logic [15:0] ROM_BANK_WIN = 16'h4000;

  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  write_data;
  } bus_access_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rom_fetch;
    logic [18:0] rom_location;
  } read_result_t;

  typedef struct packed {
    logic [1:0]  mapper;
    logic [19:0] rom_bytes;
    logic [17:0] ram_bytes;
    logic        rumble;
  } mapping_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_SPARSE,
    READY_BURSTY
  } ready_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // address[15:0], write_data[23:16]
  logic [0:0]  s_axis_tuser = '0;  // op[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // read_data[7:0], rom_location[26:8]
  logic [0:0]  m_axis_tuser;       // rom_fetch[0]

  cartridge_bank_controller u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #CLK_HALF_NS clk = ~clk;
  end

  // Mirror of the configuration registers (written by the sequencer only)
  logic [1:0]  cur_mapper    = MAPPER_BANKLESS;
  logic [19:0] cur_rom_bytes = 20'd32768;
  logic [17:0] cur_ram_bytes = 18'd0;
  logic        cur_rumble    = 1'b0;

  // Mirror of the bank state and cartridge RAM (updated by the monitor; cleared at start by the sequence)
  logic [8:0]  bank_rom = 9'd1;
  logic [3:0]  bank_ram = 4'd0;
  logic        ram_on   = 1'b0;
  logic [7:0]  mirror_ram [RAM_DEPTH];

  bus_access_t  pending_accesses [$];
  read_result_t expected_reads [$];

  int errors        = 0;
  int cycle_count   = 0;
  int n_accepted    = 0;
  int n_writes      = 0;
  int n_checked     = 0;
  int n_rom_fetches = 0;
  int n_ram_hits    = 0;
  int phase_items   = 0;

  function automatic logic is_banked(input logic [1:0] mapper);
    return (mapper == cbc_pkg::MAPPER_MBC1) || (mapper == cbc_pkg::MAPPER_MBC5);
  endfunction

  // --------------------------------------------------------------------------
  // Bank state mirror: apply one accepted access, queue the read it returns
  // --------------------------------------------------------------------------
  task automatic apply_bus_access(input bus_access_t acc);
    logic [16:0]  ram_where;
    logic [22:0]  rom_where;
    logic         banked;
    logic         mbc5;
    logic         ram_ok;
    read_result_t res;
    banked    = is_banked(cur_mapper);
    mbc5      = (cur_mapper == cbc_pkg::MAPPER_MBC5);
    ram_where = {bank_ram, 13'd0} + {4'd0, acc.address[12:0]};
    // A RAM access must land in the window and below both the configured
    // size and the built depth.
    ram_ok = ram_on && (acc.address >= RAM_WIN_BASE) && (acc.address <= 16'hbfff) &&
             ({1'b0, ram_where} < cur_ram_bytes) && (ram_where < RAM_DEPTH);
    if (acc.op == OP_WRITE) begin
      n_writes++;
      // Bankless (and the unused mapper code) ignores every write.
      if (banked) begin
        if (acc.address <= 16'h1fff) begin
          ram_on = (acc.write_data[3:0] == 4'ha);
        end else if (acc.address <= 16'h3fff) begin
          if (!mbc5) begin
            // MBC1: a zero bank number selects bank one
            bank_rom = (acc.write_data[4:0] == 5'd0) ? 9'd1 : {4'd0, acc.write_data[4:0]};
          end else if (acc.address <= 16'h2fff) begin
            bank_rom = {bank_rom[8], acc.write_data};
          end else begin
            bank_rom = {acc.write_data[0], bank_rom[7:0]};
          end
        end else if (acc.address <= 16'h5fff) begin
          if (!mbc5) bank_ram = {2'b00, acc.write_data[1:0]};
          else if (cur_rumble) bank_ram = {1'b0, acc.write_data[2:0]};
          else bank_ram = acc.write_data[3:0];
        end else if (ram_ok) begin
          mirror_ram[ram_where[12:0]] = acc.write_data;
        end
      end
    end else begin
      res = '{read_data: 8'hff, rom_fetch: 1'b0, rom_location: 19'd0};
      if ((acc.address < 16'h8000) && ({4'd0, acc.address} < cur_rom_bytes)) begin
        if (!banked || (acc.address < ROM_BANK_WIN)) rom_where = {7'd0, acc.address};
        else rom_where = {bank_rom, 14'd0} + {9'd0, acc.address[13:0]};
        // Mask to the 19-bit ROM address space of this build
        res.rom_fetch    = 1'b1;
        res.rom_location = rom_where[18:0];
        n_rom_fetches++;
      end else if (banked && ram_ok) begin
        res.read_data = mirror_ram[ram_where[12:0]];
        n_ram_hits++;
      end
      expected_reads.push_back(res);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: send pending accesses in bursts of random length, with gaps
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    bus_access_t acc;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      // The current transaction (if any) completes at this edge; load the next, or idle during a gap.
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_accesses.size() != 0) begin
        acc = pending_accesses.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {acc.write_data, acc.address};
        s_axis_tuser  <= acc.op;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          // Start a new burst; a quarter of them run back to back with no gap.
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern whose ready mode is redrawn at random after a random span of cycles
  // --------------------------------------------------------------------------
  ready_mode_e ready_mode = READY_ALWAYS;
  int          mode_left  = 0;
  int          stall_left = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode_left  = $urandom_range(50, 400);
      ready_mode = ready_mode_e'($urandom_range(0, 3));
    end else begin
      mode_left = mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: begin
        m_axis_tready <= 1'b1;
      end
      READY_MOSTLY: begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      READY_SPARSE: begin
        m_axis_tready <= ((mode_left % 3) == 0);
      end
      default: begin
        // Long stalls broken by open stretches
        if (stall_left > 0) begin
          stall_left = stall_left - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 30);
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each accepted access, check each accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bus_access_t  acc;
    read_result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        acc.op         = s_axis_tuser[0];
        acc.address    = s_axis_tdata[15:0];
        acc.write_data = s_axis_tdata[23:16];
        n_accepted++;
        apply_bus_access(acc);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_reads.size() == 0) begin
          $error("result with no read outstanding: tdata %h tuser %h",
                 m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want = expected_reads.pop_front();
          n_checked++;
          if (m_axis_tdata[7:0] !== want.read_data) begin
            $error("read_data mismatch: expected %h, actual %h",
                   want.read_data, m_axis_tdata[7:0]);
            errors++;
          end
          if (m_axis_tuser[0] !== want.rom_fetch) begin
            $error("rom_fetch mismatch: expected %h, actual %h",
                   want.rom_fetch, m_axis_tuser[0]);
            errors++;
          end
          if (m_axis_tdata[26:8] !== want.rom_location) begin
            $error("rom_location mismatch: expected %h, actual %h",
                   want.rom_location, m_axis_tdata[26:8]);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if it hangs
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer helpers
  // --------------------------------------------------------------------------
  // Queue one access and count it toward the phase.
  task automatic push_access(input logic op, input logic [15:0] address,
                             input logic [7:0] write_data);
    bus_access_t acc;
    acc = '{op: op, address: address, write_data: write_data};
    pending_accesses.push_back(acc);
    phase_items++;
  endtask

  // Hold until every access is sent and every read has returned, then settle.
  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while ((pending_accesses.size() != 0) || s_axis_tvalid ||
               (expected_reads.size() != 0));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register on the next edge; call only while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [19:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      cbc_pkg::CFG_MAPPER_KIND: cur_mapper    = value[1:0];
      cbc_pkg::CFG_ROM_SIZE:    cur_rom_bytes = value;
      cbc_pkg::CFG_RAM_SIZE:    cur_ram_bytes = value[17:0];
      default:                  cur_rumble    = value[0];
    endcase
  endtask

  task automatic apply_mapping(input mapping_t m);
    write_reg(cbc_pkg::CFG_MAPPER_KIND, {18'd0, m.mapper});
    write_reg(cbc_pkg::CFG_ROM_SIZE, m.rom_bytes);
    write_reg(cbc_pkg::CFG_RAM_SIZE, {2'b00, m.ram_bytes});
    write_reg(cbc_pkg::CFG_RUMBLE, {19'd0, m.rumble});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // A well-formed RAM session: enable, pick a bank, then reads and writes
  // clustered on a few offsets so that written bytes get read back.
  task automatic push_ram_session();
    int          n;
    logic [12:0] off;
    logic [7:0]  bank_byte;
    push_access(OP_WRITE, 16'($urandom_range(0, 16'h1fff)),
                {4'($urandom_range(0, 15)), 4'ha});
    bank_byte = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) bank_byte[3:0] = 4'($urandom_range(0, 1));
    push_access(OP_WRITE, 16'h4000 | 16'($urandom_range(0, 16'h1fff)), bank_byte);
    if ($urandom_range(0, 2) == 0) begin
      // Retune the ROM bank and read through the switchable window
      push_access(OP_WRITE, 16'h2000 | 16'($urandom_range(0, 16'h1fff)),
                  8'($urandom_range(0, 255)));
      push_access(OP_READ, ROM_BANK_WIN | 16'($urandom_range(0, 16'h3fff)),
                  8'($urandom_range(0, 255)));
    end
    n = $urandom_range(2, 8);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: off = 13'($urandom_range(0, 31));
        1: off = 13'h1fe0 | 13'($urandom_range(0, 31));
        default: off = 13'($urandom_range(0, 8191));
      endcase
      push_access($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                  RAM_WIN_BASE | {3'b000, off}, 8'($urandom_range(0, 255)));
    end
    // Now and then close the session with a random enable byte
    if ($urandom_range(0, 5) == 0)
      push_access(OP_WRITE, 16'($urandom_range(0, 16'h1fff)), 8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  mapping_t plan [NUM_PHASES];

  initial begin
    for (int i = 0; i < RAM_DEPTH; i++) mirror_ram[i] = 8'd0;

    // Reset once, then program the registers while the RAM clears.
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: MBC1 with a RAM size above the built depth
    apply_mapping('{mapper: cbc_pkg::MAPPER_MBC1, rom_bytes: 20'd524288,
                    ram_bytes: 18'd32768, rumble: 1'b0});
    push_access(OP_READ,  16'h0000, 8'h00);  // fixed ROM window, lowest address
    push_access(OP_READ,  16'h7fff, 8'h00);  // banked window, reset bank
    push_access(OP_WRITE, 16'h2000, 8'h00);  // bank zero maps to one
    push_access(OP_READ,  16'h4000, 8'h00);
    push_access(OP_WRITE, 16'h3fff, 8'hff);  // top of MBC1 bank range
    push_access(OP_READ,  16'h7abc, 8'h00);
    push_access(OP_WRITE, 16'h0000, 8'h0a);  // enable RAM
    push_access(OP_WRITE, 16'ha000, 8'h5a);
    push_access(OP_READ,  16'ha000, 8'h00);
    push_access(OP_WRITE, 16'h5fff, 8'h03);  // bank beyond the built store
    push_access(OP_WRITE, 16'hbfff, 8'h11);  // dropped
    push_access(OP_READ,  16'hbfff, 8'h00);  // open bus
    push_access(OP_WRITE, 16'h4000, 8'h00);
    push_access(OP_WRITE, 16'hbfff, 8'ha5);
    push_access(OP_READ,  16'hbfff, 8'h00);
    push_access(OP_WRITE, 16'h1fff, 8'hfb);  // wrong key disables RAM
    push_access(OP_READ,  16'ha000, 8'h00);
    push_access(OP_READ,  16'h8000, 8'h00);  // unmapped
    push_access(OP_READ,  16'hffff, 8'h00);
    push_access(OP_WRITE, 16'h6000, 8'hff);  // ignored range
    wait_idle();

    // Directed: switch to MBC5 with rumble; bank registers carry over
    apply_mapping('{mapper: cbc_pkg::MAPPER_MBC5, rom_bytes: 20'd524288,
                    ram_bytes: 18'd8192, rumble: 1'b1});
    push_access(OP_READ,  16'h4000, 8'h00);
    push_access(OP_WRITE, 16'h2fff, 8'hff);  // low eight bank bits
    push_access(OP_WRITE, 16'h3000, 8'h01);  // bank bit eight
    push_access(OP_READ,  16'h7fff, 8'h00);  // highest bank, masked location
    push_access(OP_WRITE, 16'h4000, 8'hff);  // rumble limits bank to three bits
    wait_idle();

    // Random phases over a spread of settings, extremes included
    plan[0] = '{cbc_pkg::MAPPER_MBC1, 20'd524288, 18'd8192,   1'b0};
    plan[1] = '{cbc_pkg::MAPPER_MBC5, 20'd524288, 18'd131072, 1'b0};
    plan[2] = '{cbc_pkg::MAPPER_MBC5, 20'd262144, 18'd65536,  1'b1};
    plan[3] = '{MAPPER_BANKLESS,      20'd32768,  18'd8192,   1'b0};
    plan[4] = '{cbc_pkg::MAPPER_MBC1, 20'd0,      18'd2048,   1'b0};
    plan[5] = '{MAPPER_UNUSED,        20'd32768,  18'd8192,   1'b1};
    plan[6] = '{cbc_pkg::MAPPER_MBC5, 20'd16384,  18'd0,      1'b0};
    plan[7] = '{cbc_pkg::MAPPER_MBC1, 20'd131072, 18'd4096,   1'b1};
    plan[8] = '{2'($urandom_range(0, 3)), 20'($urandom_range(0, 524288)),
                18'($urandom_range(0, 131072)), 1'($urandom_range(0, 1))};
    plan[9] = '{cbc_pkg::MAPPER_MBC5, 20'd524288, 18'd8192,   1'b0};

    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_mapping(plan[p]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: push_ram_session();
          6, 7: push_access(OP_READ, 16'($urandom_range(0, 16'h7fff)),
                            8'($urandom_range(0, 255)));
          default: push_access($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                               16'($urandom_range(0, 65535)),
                               8'($urandom_range(0, 255)));
        endcase
      end
      // Pause the sender until every read of this phase has come back.
      wait_idle();
    end

    if (expected_reads.size() != 0) begin
      $error("%0d reads never returned a result", expected_reads.size());
      errors++;
    end
    $display("Sent %0d bus accesses over %0d mapper settings: %0d writes, %0d reads checked.",
             n_accepted, NUM_PHASES + 2, n_writes, n_checked);
    $display("Reads covered %0d ROM fetches and %0d cartridge RAM hits under random stalls.",
             n_rom_fetches, n_ram_hits);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- cartridge_bank_controller.f -----
hw/rtl/cbc_pkg.sv
hw/rtl/cbc_ram.sv
hw/rtl/cbc_mapper.sv
hw/rtl/cartridge_bank_controller.sv
verif/tb_cartridge_bank_controller.sv
